@@ src/ktt_pkg.sv @@
// Shared types, codes and sizes of the keyed timer table.
`default_nettype none
package ktt_pkg;

  localparam int KTT_DEPTH = 32;
  localparam int DUE_W     = 49;

  localparam logic [1:0] ACT_SCHED  = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_RUN    = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic [31:0] WAIT_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] WAIT_NONE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] callback_id;
    logic [31:0] context_req;
    logic [30:0] delay_ms;
    logic [47:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               status;
    logic [15:0]        fired_callback;
    logic [31:0]        fired_context;
    logic signed [31:0] soonest_wait;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic       start;
    logic       advance;
    logic       kill;
    logic       wr_due;
    logic       wr_new;
    logic       clear_all;
    logic       emit;
    logic [1:0] emit_kind;
    logic       emit_status;
    logic       emit_last;
  } ktt_ctl_t;

  typedef struct packed {
    logic [1:0] action;
    logic       at_end;
    logic       key_hit;
    logic       due_hit;
    logic       slot_avail;
    logic       out_ready;
  } ktt_sts_t;

endpackage
`default_nettype wire

@@ src/keyed_timer_table_top.sv @@
// Top level of the keyed timer table: controller and datapath.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | in_data   (in_item_t)
//  out_    | output    | out_valid/out_stall | out_data  (out_item_t)
//
// The scan steps through the entry store read port one slot per cycle, pausing on a fired
// timer only while the result side stalls; a schedule or cancel that finds its key stops
// the scan there, and a run emits each fired timer as the scan passes it.
// in_stall is high from acceptance until the final result is loaded into the output
// register, which also holds while out_stall is high. Synchronous active-low reset
// empties the table at once.
`default_nettype none
module keyed_timer_table_top import ktt_pkg::*; #(
  parameter int TABLE_DEPTH = KTT_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  ktt_ctl_t ctl;
  ktt_sts_t sts;

  ktt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  ktt_dp #(.DEPTH(TABLE_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ src/ktt_dp.sv @@
// Datapath of the keyed timer table: entry stores, live bits, scan index and result register.
`default_nettype none
module ktt_dp import ktt_pkg::*; #(
  parameter int DEPTH = KTT_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire ktt_ctl_t  ctl,
  output ktt_sts_t       sts,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [15:0]      mem_cb  [DEPTH];
  logic [31:0]      mem_ctx [DEPTH];
  logic [DUE_W-1:0] mem_due [DEPTH];

  in_item_t         item_r;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    hw_r, hw_nxt;
  logic [CW-1:0]    free_r, free_nxt;
  logic             free_v_r, free_v_nxt;
  logic             any_r, any_nxt;
  logic [DUE_W-1:0] best_r, best_nxt;
  logic [DEPTH-1:0] live_r, live_nxt;
  logic [15:0]      rd_cb_r;
  logic [31:0]      rd_ctx_r;
  logic [DUE_W-1:0] rd_due_r;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [IW-1:0]    rd_addr, cur, wr_addr;
  logic [CW-1:0]    target;
  logic [DUE_W-1:0] now_ext, due_new, wait_cur;
  logic             cur_live;
  logic [31:0]      wait_out;

  assign cur      = idx_r[IW-1:0];
  assign cur_live = live_r[cur];
  assign now_ext  = {1'b0, item_r.current_time};
  assign due_new  = now_ext + {{(DUE_W-31){1'b0}}, item_r.delay_ms};
  assign wait_cur = rd_due_r - now_ext;
  assign target   = free_v_r ? free_r : hw_r;
  assign wr_addr  = ctl.wr_new ? target[IW-1:0] : cur;

  always_comb begin
    if (ctl.start) begin
      rd_addr = '0;
    end else if (ctl.advance) begin
      rd_addr = IW'(idx_r + CW'(1));
    end else begin
      rd_addr = cur;
    end
  end

  assign sts.action     = item_r.action;
  assign sts.at_end     = (idx_r == hw_r);
  assign sts.key_hit    = cur_live && (rd_cb_r == item_r.callback_id)
                          && (rd_ctx_r == item_r.context_req);
  assign sts.due_hit    = cur_live && (rd_due_r <= now_ext);
  assign sts.slot_avail = free_v_r || (hw_r != DEPTH_C);
  assign sts.out_ready  = !out_valid_r || !out_stall;

  always_comb begin
    if (!any_r) begin
      wait_out = WAIT_NONE;
    end else if (best_r > {{(DUE_W-32){1'b0}}, WAIT_MAX}) begin
      wait_out = WAIT_MAX;
    end else begin
      wait_out = best_r[31:0];
    end
  end

  always_comb begin
    idx_nxt    = idx_r;
    free_nxt   = free_r;
    free_v_nxt = free_v_r;
    any_nxt    = any_r;
    best_nxt   = best_r;
    live_nxt   = live_r;
    hw_nxt     = hw_r;
    if (ctl.start) begin
      idx_nxt    = '0;
      free_v_nxt = 1'b0;
      any_nxt    = 1'b0;
    end
    if (ctl.advance) begin
      idx_nxt = idx_r + CW'(1);
      if (!cur_live && !free_v_r) begin
        free_nxt   = idx_r;
        free_v_nxt = 1'b1;
      end
      if (cur_live && !sts.due_hit && (!any_r || wait_cur < best_r)) begin
        best_nxt = wait_cur;
      end
      if (cur_live && !sts.due_hit) begin
        any_nxt = 1'b1;
      end
    end
    if (ctl.kill) begin
      live_nxt[cur] = 1'b0;
    end
    if (ctl.wr_new) begin
      live_nxt[target[IW-1:0]] = 1'b1;
      if (!free_v_r) begin
        hw_nxt = hw_r + CW'(1);
      end
    end
    if (ctl.clear_all) begin
      live_nxt = '0;
      hw_nxt   = '0;
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (ctl.emit) begin
      out_valid_nxt          = 1'b1;
      out_nxt                = '0;
      out_nxt.kind           = ctl.emit_kind;
      out_nxt.status         = ctl.emit_status;
      out_nxt.last           = ctl.emit_last;
      if (ctl.emit_kind == KIND_FIRED) begin
        out_nxt.fired_callback = rd_cb_r;
        out_nxt.fired_context  = rd_ctx_r;
      end
      if (ctl.emit_kind == KIND_DONE) begin
        out_nxt.soonest_wait = wait_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_new) begin
      mem_cb[wr_addr]  <= item_r.callback_id;
      mem_ctx[wr_addr] <= item_r.context_req;
    end
    if (ctl.wr_new || ctl.wr_due) begin
      mem_due[wr_addr] <= due_new;
    end
    rd_cb_r  <= mem_cb[rd_addr];
    rd_ctx_r <= mem_ctx[rd_addr];
    rd_due_r <= mem_due[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      item_r <= in_data;
    end
    idx_r  <= idx_nxt;
    free_r <= free_nxt;
    best_r <= best_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= '0;
      hw_r        <= '0;
      free_v_r    <= 1'b0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      live_r      <= live_nxt;
      hw_r        <= hw_nxt;
      free_v_r    <= free_v_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ src/ktt_ctrl.sv @@
// Controller of the keyed timer table: accepts a transaction and sequences the slot scan.
`default_nettype none
module ktt_ctrl import ktt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire ktt_sts_t sts,
  output ktt_ctl_t      ctl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        case (sts.action)
          ACT_CLEAR: begin
            if (sts.out_ready) begin
              ctl.clear_all = 1'b1;
              ctl.emit      = 1'b1;
              ctl.emit_kind = KIND_STATUS;
              ctl.emit_last = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          ACT_RUN: begin
            if (!sts.at_end) begin
              if (!sts.due_hit) begin
                ctl.advance = 1'b1;
              end else if (sts.out_ready) begin
                ctl.kill      = 1'b1;
                ctl.advance   = 1'b1;
                ctl.emit      = 1'b1;
                ctl.emit_kind = KIND_FIRED;
              end
            end else if (sts.out_ready) begin
              ctl.emit      = 1'b1;
              ctl.emit_kind = KIND_DONE;
              ctl.emit_last = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          default: begin
            if (!sts.at_end && !sts.key_hit) begin
              ctl.advance = 1'b1;
            end else if (sts.out_ready) begin
              ctl.emit      = 1'b1;
              ctl.emit_kind = KIND_STATUS;
              ctl.emit_last = 1'b1;
              state_nxt     = S_IDLE;
              if (!sts.at_end) begin
                ctl.kill   = (sts.action == ACT_CANCEL);
                ctl.wr_due = (sts.action == ACT_SCHED);
              end else if (sts.action == ACT_SCHED) begin
                ctl.wr_new      = sts.slot_avail;
                ctl.emit_status = !sts.slot_avail;
              end
            end
          end
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire
